// ----- src/dlwe_pkg.sv -----
// Shared types and codes for the daily load window block.
// No dependencies; imported by the front, queue, back and top level.
`default_nettype none

package dlwe_pkg;

   // Default window depth in days
   localparam int HISTORY_DAYS_DEF = 64;

   // Reset value of the earliest accepted Unix time
   localparam logic [31:0] MIN_VALID_RESET = 32'd1577836800;

   // Request opcodes; the spare code, and an add of zero load, act as a plain query
   localparam logic [1:0] OPC_SET_CLOCK = 2'd0;
   localparam logic [1:0] OPC_ADD_LOAD  = 2'd1;
   localparam logic [1:0] OPC_QUERY     = 2'd2;
   localparam logic [1:0] OPC_SPARE     = 2'd3;

   // Work kinds handed from front to back
   localparam logic [1:0] KIND_CLOCK = 2'd0;
   localparam logic [1:0] KIND_ADD   = 2'd1;
   localparam logic [1:0] KIND_QUERY = 2'd2;

   // One classified request
   typedef struct packed {
      logic [1:0]  kind;
      logic        time_ok;
      logic [15:0] day;
      logic [15:0] load;
      logic [9:0]  ago;
      logic [10:0] peak_days;
      logic [15:0] extra;
   } work_type;

endpackage

`default_nettype wire

// ----- src/dlwe_front.sv -----
// Front end: accepts requests, turns Unix time into a day number, classifies.
// Depends on dlwe_pkg; feeds dlwe_queue.
`default_nettype none

module dlwe_front import dlwe_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_opcode,
   input  wire logic [31:0] req_unix_time,
   input  wire logic [15:0] req_load_tenths,
   input  wire logic [9:0]  req_days_ago,
   input  wire logic [10:0] req_peak_days,
   input  wire logic [15:0] req_extra_tenths,
   input  wire logic [31:0] min_valid_time,
   input  wire logic        back_ready,
   input  wire logic        q_full,
   output logic             q_push,
   output work_type         q_data
);

   // day = (t >> 7) / 675, exact via ceil(2^35 / 675) for 25-bit numerators
   localparam logic [25:0] DAY_RECIP = 26'd50903317;

   localparam logic [1:0] FS_IDLE = 2'd0;
   localparam logic [1:0] FS_MUL  = 2'd1;
   localparam logic [1:0] FS_PUSH = 2'd2;

   logic [1:0]  state_ff, state_in;
   logic [1:0]  op_ff;
   logic [31:0] time_ff;
   logic [15:0] load_ff, extra_ff;
   logic [9:0]  ago_ff;
   logic [10:0] pk_ff;
   logic [50:0] prod_ff;
   logic        ok_ff;
   logic        accept;

   assign busy   = (state_ff != FS_IDLE) || !back_ready;
   assign accept = start && !busy;
   assign q_push = (state_ff == FS_PUSH) && !q_full;

   // Sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FS_IDLE: if (accept) state_in = FS_MUL;
         FS_MUL:  state_in = FS_PUSH;
         FS_PUSH: if (!q_full) state_in = FS_IDLE;
         default: state_in = FS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Request capture and day-number multiply
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= req_opcode;
         time_ff  <= req_unix_time;
         load_ff  <= req_load_tenths;
         ago_ff   <= req_days_ago;
         pk_ff    <= req_peak_days;
         extra_ff <= req_extra_tenths;
      end
      if (state_ff == FS_MUL) begin
         prod_ff <= {26'd0, time_ff[31:7]} * {25'd0, DAY_RECIP};
         ok_ff   <= (time_ff >= min_valid_time);
      end
   end

   // Classification
   always_comb begin
      q_data.time_ok   = ok_ff;
      q_data.day       = prod_ff[50:35];
      q_data.load      = load_ff;
      q_data.ago       = ago_ff;
      q_data.peak_days = pk_ff;
      q_data.extra     = extra_ff;
      if (op_ff == OPC_SET_CLOCK) begin
         q_data.kind = KIND_CLOCK;
      end else if (op_ff == OPC_ADD_LOAD && load_ff != 16'd0) begin
         q_data.kind = KIND_ADD;
      end else begin
         q_data.kind = KIND_QUERY;
      end
   end

endmodule

`default_nettype wire

// ----- src/dlwe_queue.sv -----
// Two-entry queue of classified requests between front and back.
// Depends on dlwe_pkg for the entry type.
`default_nettype none

module dlwe_queue import dlwe_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic push,
   input  work_type  push_data,
   output logic      full,
   input  wire logic pop,
   output work_type  pop_data,
   output logic      empty
);

   work_type   entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign pop_data = entry_ff[rd_ptr_ff];

   // Pointer and fill update
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_data;
   end

endmodule

`default_nettype wire

// ----- src/dlwe_back.sv -----
// Back end: day history memory, clock roll, load add and the window walk
// (peak, week sum, day value, two exponential averages). Depends on dlwe_pkg.
`default_nettype none

module dlwe_back import dlwe_pkg::*; #(
   parameter int HISTORY_DAYS = HISTORY_DAYS_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,
   output logic       ready,
   input  wire logic  q_empty,
   output logic       q_pop,
   input  work_type   q_data,
   output logic       rsp_valid,
   output logic [15:0] rsp_day_load,
   output logic [18:0] rsp_week_load,
   output logic [15:0] rsp_peak_load,
   output logic [15:0] rsp_fitness,
   output logic [15:0] rsp_fatigue
);

   localparam int SLOT_W = $clog2(HISTORY_DAYS);
   localparam logic [SLOT_W-1:0] LAST = SLOT_W'(HISTORY_DAYS - 1);

   // Per-lane divide constants: lane 0 divisor 42, lane 1 divisor 7
   localparam logic [5:0]  LANE_DIV [2] = '{6'd42, 6'd7};
   localparam logic [17:0] LANE_MH  [2] = '{18'd199729, 18'd149797};
   localparam int          LANE_KH  [2] = '{23, 20};
   localparam logic [23:0] LANE_ML  [2] = '{24'd12782641, 24'd1198373};
   localparam int          LANE_KL  [2] = '{29, 23};

   localparam logic [3:0] BS_INIT    = 4'd0;
   localparam logic [3:0] BS_IDLE    = 4'd1;
   localparam logic [3:0] BS_DISP    = 4'd2;
   localparam logic [3:0] BS_SHIFT   = 4'd3;
   localparam logic [3:0] BS_FULL    = 4'd4;
   localparam logic [3:0] BS_ADD_RD  = 4'd5;
   localparam logic [3:0] BS_ADD_WR  = 4'd6;
   localparam logic [3:0] BS_WALK_RD = 4'd7;
   localparam logic [3:0] BS_WALK    = 4'd8;
   localparam logic [3:0] BS_DONE    = 4'd9;

   localparam logic [2:0] PH_LAST = 3'd4;

   function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
      slot_inc = (s == LAST) ? '0 : s + 1'b1;
   endfunction

   logic [3:0]        state_ff, state_in;
   logic [SLOT_W-1:0] today_ff, today_in;
   logic [15:0]       newest_ff, newest_in;
   logic [SLOT_W-1:0] cnt_ff, cnt_in;
   logic              ready_ff, ready_in;
   logic              rsp_valid_ff, rsp_valid_in;
   work_type          cur_ff;
   logic [SLOT_W-1:0] slot_ff;
   logic [SLOT_W-1:0] k_ff;
   logic [2:0]        ph_ff;
   logic [15:0]       rd_ff;
   logic [18:0]       week_ff;
   logic [15:0]       peak_ff, dayv_ff;
   logic [15:0]       fit_ff, fat_ff;
   logic [32:0]       v_ff [2];
   logic [15:0]       sat_out [2];

   logic [15:0]       shift16;
   logic [16:0]       add_sum;
   logic [16:0]       t_ext;
   logic [10:0]       k11;

   // Memory port controls
   logic              mem_we, mem_re;
   logic [SLOT_W-1:0] mem_waddr, mem_raddr;
   logic [15:0]       mem_wdata;
   logic [15:0]       mem [HISTORY_DAYS];

   assign ready     = ready_ff;
   assign rsp_valid = rsp_valid_ff;
   assign q_pop     = (state_ff == BS_IDLE) && !q_empty;
   assign shift16   = cur_ff.day - newest_ff;
   assign add_sum   = {1'b0, rd_ff} + {1'b0, cur_ff.load};
   assign t_ext     = {1'b0, rd_ff} + ((k_ff == '0) ? {1'b0, cur_ff.extra} : 17'd0);
   assign k11       = 11'(k_ff);

   // Control next state
   always_comb begin
      state_in     = state_ff;
      today_in     = today_ff;
      newest_in    = newest_ff;
      cnt_in       = cnt_ff;
      ready_in     = ready_ff;
      rsp_valid_in = 1'b0;
      case (state_ff)
         BS_INIT: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST) begin
               ready_in = 1'b1;
               state_in = BS_IDLE;
            end
         end
         BS_IDLE: if (!q_empty) state_in = BS_DISP;
         BS_DISP: begin
            case (cur_ff.kind)
               KIND_CLOCK: begin
                  state_in = BS_WALK_RD;
                  if (cur_ff.time_ok) begin
                     if (newest_ff == 16'd0) begin
                        newest_in = cur_ff.day;
                     end else if (cur_ff.day > newest_ff) begin
                        newest_in = cur_ff.day;
                        if ({1'b0, shift16} >= 17'(HISTORY_DAYS)) begin
                           cnt_in   = '0;
                           state_in = BS_FULL;
                        end else begin
                           cnt_in   = shift16[SLOT_W-1:0];
                           state_in = BS_SHIFT;
                        end
                     end
                  end
               end
               KIND_ADD: state_in = BS_ADD_RD;
               default:  state_in = BS_WALK_RD;
            endcase
         end
         BS_SHIFT: begin
            today_in = slot_inc(today_ff);
            cnt_in   = cnt_ff - 1'b1;
            if (cnt_ff == SLOT_W'(1)) state_in = BS_WALK_RD;
         end
         BS_FULL: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST) state_in = BS_WALK_RD;
         end
         BS_ADD_RD:  state_in = BS_ADD_WR;
         BS_ADD_WR:  state_in = BS_WALK_RD;
         BS_WALK_RD: state_in = BS_WALK;
         BS_WALK: begin
            if (ph_ff == PH_LAST && k_ff == '0) state_in = BS_DONE;
         end
         BS_DONE: begin
            rsp_valid_in = 1'b1;
            state_in     = BS_IDLE;
         end
         default: state_in = BS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BS_INIT;
         today_ff     <= '0;
         newest_ff    <= 16'd0;
         cnt_ff       <= '0;
         ready_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         today_ff     <= today_in;
         newest_ff    <= newest_in;
         cnt_ff       <= cnt_in;
         ready_ff     <= ready_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Memory port selection
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = cnt_ff;
      mem_wdata = 16'd0;
      mem_re    = 1'b0;
      mem_raddr = today_ff;
      case (state_ff)
         BS_INIT, BS_FULL: mem_we = 1'b1;
         BS_SHIFT: begin
            mem_we    = 1'b1;
            mem_waddr = slot_inc(today_ff);
         end
         BS_ADD_RD: mem_re = 1'b1;
         BS_ADD_WR: begin
            mem_we    = 1'b1;
            mem_waddr = today_ff;
            mem_wdata = add_sum[16] ? 16'hFFFF : add_sum[15:0];
         end
         BS_WALK_RD: begin
            mem_re    = 1'b1;
            mem_raddr = slot_inc(today_ff);
         end
         BS_WALK: begin
            mem_re    = (ph_ff == PH_LAST) && (k_ff != '0);
            mem_raddr = slot_inc(slot_ff);
         end
         default: mem_re = 1'b0;
      endcase
   end

   // Day history store
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      if (mem_re) rd_ff <= mem[mem_raddr];
   end

   // Walk bookkeeping: order, phase, week, peak and chosen day
   always_ff @(posedge clock) begin
      if (q_pop) cur_ff <= q_data;
      if (state_ff == BS_WALK_RD) begin
         slot_ff <= slot_inc(today_ff);
         k_ff    <= LAST;
         ph_ff   <= 3'd0;
         week_ff <= 19'd0;
         peak_ff <= 16'd0;
         dayv_ff <= 16'd0;
      end else if (state_ff == BS_WALK) begin
         if (ph_ff == PH_LAST) begin
            ph_ff   <= 3'd0;
            k_ff    <= k_ff - 1'b1;
            slot_ff <= slot_inc(slot_ff);
         end else begin
            ph_ff <= ph_ff + 3'd1;
         end
         if (ph_ff == 3'd0) begin
            if (k11 < cur_ff.peak_days && rd_ff > peak_ff) peak_ff <= rd_ff;
            if (k_ff < SLOT_W'(7)) week_ff <= week_ff + {3'd0, rd_ff};
            if (k11 == {1'b0, cur_ff.ago}) dayv_ff <= rd_ff;
         end
      end
   end

   // Averaging lanes: v += trunc(((t << 16) - v) / D) over five phases per day
   for (genvar g = 0; g < 2; g++) begin : g_lane
      localparam logic [5:0]  D  = LANE_DIV[g];
      localparam logic [17:0] MH = LANE_MH[g];
      localparam int          KH = LANE_KH[g];
      localparam logic [23:0] ML = LANE_ML[g];
      localparam int          KL = LANE_KL[g];

      logic [32:0] a_ff;
      logic        s_ff;
      logic [15:0] qh_ff;
      logic [5:0]  rh_ff;
      logic [16:0] ql_ff;
      logic [33:0] diff;
      logic [33:0] mag;
      logic [33:0] hprod, hshr;
      logic [21:0] qd, rh22;
      logic [22:0] xlo;
      logic [46:0] lprod, lshr;
      logic [32:0] q;
      logic [33:0] rnd;

      assign diff  = {1'b0, t_ext, 16'd0} - {1'b0, v_ff[g]};
      assign mag   = diff[33] ? (34'd0 - diff) : diff;
      assign hprod = {18'd0, a_ff[32:17]} * {16'd0, MH};
      assign hshr  = hprod >> KH;
      assign qd    = {6'd0, qh_ff} * {16'd0, D};
      assign rh22  = {6'd0, a_ff[32:17]} - qd;
      assign xlo   = {rh_ff, a_ff[16:0]};
      assign lprod = {24'd0, xlo} * {23'd0, ML};
      assign lshr  = lprod >> KL;
      assign q     = {qh_ff, 17'd0} + {16'd0, ql_ff};
      assign rnd   = {1'b0, v_ff[g]} + 34'd32768;
      assign sat_out[g] = (rnd[33:16] > 18'd65535) ? 16'hFFFF : rnd[31:16];

      always_ff @(posedge clock) begin
         if (state_ff == BS_WALK_RD) begin
            v_ff[g] <= 33'd0;
         end else if (state_ff == BS_WALK) begin
            case (ph_ff)
               3'd0: begin
                  a_ff <= mag[32:0];
                  s_ff <= diff[33];
               end
               3'd1: qh_ff <= hshr[15:0];
               3'd2: rh_ff <= rh22[5:0];
               3'd3: ql_ff <= lshr[16:0];
               default: v_ff[g] <= s_ff ? (v_ff[g] - q) : (v_ff[g] + q);
            endcase
         end
      end
   end

   // Result register, loaded once per request
   always_ff @(posedge clock) begin
      if (state_ff == BS_DONE) begin
         fit_ff <= sat_out[0];
         fat_ff <= sat_out[1];
      end
   end

   assign rsp_day_load  = dayv_ff;
   assign rsp_week_load = week_ff;
   assign rsp_peak_load = peak_ff;
   assign rsp_fitness   = fit_ff;
   assign rsp_fatigue   = fat_ff;

endmodule

`default_nettype wire

// ----- src/daily_load_window_ema.sv -----
// Top level of the daily load window: config register, front, queue, back.
// Depends on dlwe_pkg, dlwe_front, dlwe_queue and dlwe_back.
//
//   Port group   Handshake               Contents
//   req_*        start / busy            opcode, time, load, day, peak span, extra
//   rsp_*        rsp_valid (1 cycle)     day, week, peak, fitness, fatigue
//   csr_*        csr_wr_en               min_valid_time
//
// A query's response strobe follows accept through the front's multiply and push
// states, the queue hop, dispatch, the first read, five phases per stored day in
// the two divide-by-constant averaging lanes and a final state. An add also
// reads and writes the day's entry; a clock step also clears one slot per skipped
// day, or every slot for a full clear. After reset the history memory is zeroed
// one entry per cycle while busy is high. The strobe cannot be stalled.
`default_nettype none

module daily_load_window_ema import dlwe_pkg::*; #(
   parameter int HISTORY_DAYS = HISTORY_DAYS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_opcode,
   input  wire logic [31:0] req_unix_time,
   input  wire logic [15:0] req_load_tenths,
   input  wire logic [9:0]  req_days_ago,
   input  wire logic [10:0] req_peak_days,
   input  wire logic [15:0] req_extra_tenths,
   output logic             rsp_valid,
   output logic [15:0]      rsp_day_load,
   output logic [18:0]      rsp_week_load,
   output logic [15:0]      rsp_peak_load,
   output logic [15:0]      rsp_fitness,
   output logic [15:0]      rsp_fatigue,
   input  wire logic        csr_wr_en,
   input  wire logic [31:0] csr_wr_data
);

   logic [31:0] min_time_ff;
   logic        back_ready;
   logic        q_full, q_empty, q_push, q_pop;
   work_type    push_data, pop_data;

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         min_time_ff <= MIN_VALID_RESET;
      end else if (csr_wr_en) begin
         min_time_ff <= csr_wr_data;
      end
   end

   dlwe_front u_front (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_opcode       (req_opcode),
      .req_unix_time    (req_unix_time),
      .req_load_tenths  (req_load_tenths),
      .req_days_ago     (req_days_ago),
      .req_peak_days    (req_peak_days),
      .req_extra_tenths (req_extra_tenths),
      .min_valid_time   (min_time_ff),
      .back_ready       (back_ready),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_data           (push_data)
   );

   dlwe_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (pop_data),
      .empty     (q_empty)
   );

   dlwe_back #(
      .HISTORY_DAYS (HISTORY_DAYS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .ready         (back_ready),
      .q_empty       (q_empty),
      .q_pop         (q_pop),
      .q_data        (pop_data),
      .rsp_valid     (rsp_valid),
      .rsp_day_load  (rsp_day_load),
      .rsp_week_load (rsp_week_load),
      .rsp_peak_load (rsp_peak_load),
      .rsp_fitness   (rsp_fitness),
      .rsp_fatigue   (rsp_fatigue)
   );

   // A response strobe is never held high back to back
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe held");

   // An accepted request makes the front busy as its state leaves idle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("front not busy after accept");

   // The queue is never pushed while full
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("queue overflow");

endmodule

`default_nettype wire
